@@ rtl/assert_macros.svh @@
// assertion macros shared by the rle decoder rtl
// no dependencies; the bodies are empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/lrd_pkg.sv @@
// shared types, character codes and match tables for the rle pattern decoder
// no dependencies
package lrd_pkg;

    typedef enum logic [6:0] {
        MODE_NORMAL  = 7'b0000001,
        MODE_COMMENT = 7'b0000010,
        MODE_HEADER  = 7'b0000100,
        MODE_SEARCH  = 7'b0001000,
        MODE_POSX    = 7'b0010000,
        MODE_POSY    = 7'b0100000,
        MODE_XCHECK  = 7'b1000000
    } t_line_mode;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic res_valid;
        logic seg_valid;
        logic done;
    } t_res_flags;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_X     = 8'h78;

    // match position of the last header character
    localparam logic [2:0] HDR_LAST = 3'd5;
    localparam logic [2:0] POS_LAST = 3'd3;

    // progress of a pos number
    localparam logic [2:0] PH_NONE   = 3'd0;
    localparam logic [2:0] PH_BLANK  = 3'd1;
    localparam logic [2:0] PH_SIGN   = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h23;
            3'd1:    ch = 8'h43;
            3'd2:    ch = 8'h58;
            3'd3:    ch = 8'h52;
            3'd4:    ch = 8'h4C;
            3'd5:    ch = 8'h45;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] pos_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = 8'h50;
            2'd1:    ch = 8'h6F;
            2'd2:    ch = 8'h73;
            default: ch = 8'h3D;
        endcase
        return ch;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
               (c == CH_CR);
    endfunction

endpackage

@@ rtl/lrd_core.sv @@
// per-byte decode state and next-state logic of the rle pattern decoder
// depends on lrd_pkg
module lrd_core #(
    parameter int COORD_WIDTH = 32,
    parameter int RUN_WIDTH   = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  lrd_pkg::t_in_item      i_item,
    input  logic                   i_use_position,
    output lrd_pkg::t_res_flags    o_flags,
    output logic [COORD_WIDTH-1:0] o_seg_x,
    output logic [COORD_WIDTH-1:0] o_seg_y,
    output logic [RUN_WIDTH-1:0]   o_seg_len,
    output logic [31:0]            o_total
);

    localparam int CW = COORD_WIDTH;
    localparam int RW = RUN_WIDTH;
    localparam int SW = ((CW > RW) ? CW : RW) + 2;

    localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] MAG_LIMIT = {1'b1, {(CW-1){1'b0}}};
    localparam logic [RW-1:0] RUN_MAX   = {RW{1'b1}};

    lrd_pkg::t_line_mode r_mode, n_mode;
    logic [2:0]    r_hmp, n_hmp;
    logic [CW-1:0] r_offx, n_offx;
    logic [CW-1:0] r_offy, n_offy;
    logic [CW-1:0] r_acc, n_acc;
    logic          r_neg, n_neg;
    logic [CW-1:0] r_cx, n_cx;
    logic [CW-1:0] r_cy, n_cy;
    logic [RW-1:0] r_run, n_run;
    logic          r_has, n_has;
    logic          r_stopped, n_stopped;
    logic [31:0]   r_total, n_total;

    logic [7:0]    c;
    logic [3:0]    dval;
    logic [RW-1:0] run_eff;
    logic [RW+3:0] run_wide;
    logic [RW-1:0] run_digit;
    logic [CW+3:0] num_wide;
    logic [CW-1:0] num_digit;
    logic [CW-1:0] num_val;
    logic [SW-1:0] cx_sum;
    logic [SW-1:0] cy_sum;
    logic [CW-1:0] cx_adv;
    logic [CW-1:0] cy_adv;
    logic [CW:0]   sx;
    logic [CW:0]   sy;
    logic [CW-1:0] seg_x;
    logic [CW-1:0] seg_y;
    logic [32:0]   tot_sum;
    logic [31:0]   tot_adv;
    logic [31:0]   total_new;
    logic          tag;
    logic          emit;

    assign c    = i_item.text_byte;
    assign dval = c[3:0];

    assign run_eff   = (r_run == '0) ? RW'(1) : r_run;
    assign run_wide  = {r_run, 3'b000} + {2'b00, r_run, 1'b0} + (RW+4)'(dval);
    assign run_digit = (run_wide > (RW+4)'(RUN_MAX)) ? RUN_MAX : run_wide[RW-1:0];

    assign num_wide  = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + (CW+4)'(dval);
    assign num_digit = (num_wide > (CW+4)'(MAG_LIMIT)) ? MAG_LIMIT : num_wide[CW-1:0];

    always_comb begin
        if (r_hmp != lrd_pkg::PH_DIGITS) begin
            num_val = '0;
        end else if (r_neg) begin
            num_val = CW'(~r_acc + CW'(1));
        end else begin
            num_val = r_acc[CW-1] ? COORD_MAX : r_acc;
        end
    end

    // cursors never go negative
    assign cx_sum = SW'(r_cx) + SW'(run_eff);
    assign cy_sum = SW'(r_cy) + SW'(run_eff);
    assign cx_adv = (cx_sum > SW'(COORD_MAX)) ? COORD_MAX : cx_sum[CW-1:0];
    assign cy_adv = (cy_sum > SW'(COORD_MAX)) ? COORD_MAX : cy_sum[CW-1:0];

    assign sx = {r_cx[CW-1], r_cx} + {r_offx[CW-1], r_offx};
    assign sy = {r_cy[CW-1], r_cy} + {r_offy[CW-1], r_offy};
    assign seg_x = (sx[CW] != sx[CW-1]) ? (sx[CW] ? COORD_MIN : COORD_MAX) : sx[CW-1:0];
    assign seg_y = (sy[CW] != sy[CW-1]) ? (sy[CW] ? COORD_MIN : COORD_MAX) : sy[CW-1:0];

    assign tot_sum = {1'b0, r_total} + 33'(run_eff);
    assign tot_adv = tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];

    always_comb begin
        n_mode    = r_mode;
        n_hmp     = r_hmp;
        n_offx    = r_offx;
        n_offy    = r_offy;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_run     = r_run;
        n_has     = r_has;
        n_stopped = r_stopped;
        tag       = 1'b0;
        emit      = 1'b0;
        total_new = r_total;

        if (!r_stopped) begin
            unique case (r_mode)
                lrd_pkg::MODE_NORMAL: begin
                    if (lrd_pkg::is_digit(c)) begin
                        n_run = run_digit;
                        n_has = 1'b1;
                    end else if (r_has) begin
                        tag = 1'b1;
                    end else if (c == lrd_pkg::CH_HASH) begin
                        if (i_use_position) begin
                            n_mode = lrd_pkg::MODE_HEADER;
                            n_hmp  = 3'd1;
                        end else begin
                            n_mode = lrd_pkg::MODE_COMMENT;
                        end
                    end else if (c == lrd_pkg::CH_X) begin
                        n_mode = lrd_pkg::MODE_XCHECK;
                    end else if (c != lrd_pkg::CH_LF && c != lrd_pkg::CH_CR &&
                                 c != lrd_pkg::CH_SPACE) begin
                        tag = 1'b1;
                    end
                end
                lrd_pkg::MODE_COMMENT: begin
                    if (c == lrd_pkg::CH_LF) begin
                        n_mode = lrd_pkg::MODE_NORMAL;
                    end
                end
                lrd_pkg::MODE_HEADER: begin
                    if (c == lrd_pkg::hdr_char(r_hmp)) begin
                        if (r_hmp == lrd_pkg::HDR_LAST) begin
                            n_mode = lrd_pkg::MODE_SEARCH;
                            n_hmp  = '0;
                        end else begin
                            n_hmp = r_hmp + 3'd1;
                        end
                    end else begin
                        n_hmp  = '0;
                        n_mode = (c == lrd_pkg::CH_LF) ? lrd_pkg::MODE_NORMAL
                                                       : lrd_pkg::MODE_COMMENT;
                    end
                end
                lrd_pkg::MODE_SEARCH: begin
                    if (c == lrd_pkg::CH_LF) begin
                        n_mode = lrd_pkg::MODE_NORMAL;
                        n_hmp  = '0;
                    end else if (c == lrd_pkg::pos_char(r_hmp[1:0])) begin
                        if (r_hmp == lrd_pkg::POS_LAST) begin
                            n_mode = lrd_pkg::MODE_POSX;
                            n_hmp  = '0;
                            n_acc  = '0;
                            n_neg  = 1'b0;
                        end else begin
                            n_hmp = r_hmp + 3'd1;
                        end
                    end else begin
                        n_hmp = (c == lrd_pkg::CH_P) ? 3'd1 : 3'd0;
                    end
                end
                lrd_pkg::MODE_POSX, lrd_pkg::MODE_POSY: begin
                    if (lrd_pkg::is_digit(c)) begin
                        n_acc = num_digit;
                        n_hmp = lrd_pkg::PH_DIGITS;
                    end else if (lrd_pkg::is_blank(c) && r_hmp <= lrd_pkg::PH_BLANK) begin
                        n_hmp = lrd_pkg::PH_BLANK;
                    end else if ((c == lrd_pkg::CH_PLUS || c == lrd_pkg::CH_MINUS) &&
                                 r_hmp <= lrd_pkg::PH_BLANK) begin
                        n_neg = (c == lrd_pkg::CH_MINUS);
                        n_hmp = lrd_pkg::PH_SIGN;
                    end else begin
                        if (r_mode == lrd_pkg::MODE_POSX) begin
                            n_offx = num_val;
                        end else begin
                            n_offy = num_val;
                        end
                        n_hmp = '0;
                        n_acc = '0;
                        n_neg = 1'b0;
                        if (r_mode == lrd_pkg::MODE_POSX && c == lrd_pkg::CH_COMMA &&
                            (r_hmp == lrd_pkg::PH_NONE || r_hmp == lrd_pkg::PH_DIGITS)) begin
                            n_mode = lrd_pkg::MODE_POSY;
                        end else begin
                            n_mode = (c == lrd_pkg::CH_LF) ? lrd_pkg::MODE_NORMAL
                                                           : lrd_pkg::MODE_COMMENT;
                        end
                    end
                end
                lrd_pkg::MODE_XCHECK: begin
                    if (c == lrd_pkg::CH_SPACE || c == lrd_pkg::CH_EQ) begin
                        n_mode = lrd_pkg::MODE_COMMENT;
                    end else begin
                        n_mode    = lrd_pkg::MODE_NORMAL;
                        n_stopped = 1'b1;
                    end
                end
                default: begin
                    n_mode = lrd_pkg::MODE_NORMAL;
                end
            endcase

            if (tag) begin
                n_run = '0;
                n_has = 1'b0;
                if (c == lrd_pkg::CH_B) begin
                    n_cx = cx_adv;
                end else if (c == lrd_pkg::CH_O) begin
                    emit      = 1'b1;
                    n_cx      = cx_adv;
                    total_new = tot_adv;
                end else if (c == lrd_pkg::CH_DOLLAR) begin
                    n_cy = cy_adv;
                    n_cx = '0;
                end else begin
                    n_stopped = 1'b1;
                end
            end

            if (c == lrd_pkg::CH_NUL) begin
                n_stopped = 1'b1;
            end
        end

        n_total = total_new;

        // end of text returns everything but the config bit to reset
        if (i_item.end_of_text) begin
            n_mode    = lrd_pkg::MODE_NORMAL;
            n_hmp     = '0;
            n_offx    = '0;
            n_offy    = '0;
            n_acc     = '0;
            n_neg     = 1'b0;
            n_cx      = '0;
            n_cy      = '0;
            n_run     = '0;
            n_has     = 1'b0;
            n_stopped = 1'b0;
            n_total   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= lrd_pkg::MODE_NORMAL;
            r_hmp     <= '0;
            r_offx    <= '0;
            r_offy    <= '0;
            r_acc     <= '0;
            r_neg     <= 1'b0;
            r_cx      <= '0;
            r_cy      <= '0;
            r_run     <= '0;
            r_has     <= 1'b0;
            r_stopped <= 1'b0;
            r_total   <= '0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_hmp     <= n_hmp;
            r_offx    <= n_offx;
            r_offy    <= n_offy;
            r_acc     <= n_acc;
            r_neg     <= n_neg;
            r_cx      <= n_cx;
            r_cy      <= n_cy;
            r_run     <= n_run;
            r_has     <= n_has;
            r_stopped <= n_stopped;
            r_total   <= n_total;
        end
    end

    assign o_flags.res_valid = emit || i_item.end_of_text;
    assign o_flags.seg_valid = emit;
    assign o_flags.done      = i_item.end_of_text;
    assign o_seg_x   = emit ? seg_x : '0;
    assign o_seg_y   = emit ? seg_y : '0;
    assign o_seg_len = emit ? run_eff : '0;
    assign o_total   = total_new;

endmodule

@@ rtl/life_rle_pattern_decoder_unit.sv @@
// a byte is held in r_in and its result is registered in r_out before it reaches the master side
// throughput: one byte per cycle unless a result waits on m_tready; the per-byte state update in lrd_core is the loop
// bytes that give no result never wait on the master side
// reset: i_rst_n synchronous active low clears decode state, use_position and both stages
// top level of the rle pattern decoder; depends on lrd_pkg, lrd_core, assert_macros.svh
`include "assert_macros.svh"

module life_rle_pattern_decoder_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int RUN_WIDTH   = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // text_byte
    input  logic             s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  logic             m_tready,
    // segment_x, segment_y, segment_length, total_cells, zero fill
    output logic [((2*COORD_WIDTH+RUN_WIDTH+32+7)/8)*8-1:0] m_tdata,
    output logic             m_tuser,   // segment_valid
    output logic             m_tlast    // text_done
);

    localparam int CW      = COORD_WIDTH;
    localparam int RW      = RUN_WIDTH;
    localparam int TDATA_W = ((2*CW+RW+32+7)/8)*8;

    logic                r_use_position;
    logic                r_in_valid;
    lrd_pkg::t_in_item   r_in;
    logic                r_out_valid;
    lrd_pkg::t_res_flags r_out_flags;
    logic [CW-1:0]       r_out_x;
    logic [CW-1:0]       r_out_y;
    logic [RW-1:0]       r_out_len;
    logic [31:0]         r_out_total;

    lrd_pkg::t_res_flags core_flags;
    logic [CW-1:0]       core_x;
    logic [CW-1:0]       core_y;
    logic [RW-1:0]       core_len;
    logic [31:0]         core_total;
    logic                advance;
    logic                load_out;

    assign advance  = r_in_valid && (!core_flags.res_valid || !r_out_valid || m_tready);
    assign load_out = advance && core_flags.res_valid;
    assign s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_position <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_use_position <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in.text_byte   <= s_tdata;
            r_in.end_of_text <= s_tlast;
        end
    end

    lrd_core #(
        .COORD_WIDTH (CW),
        .RUN_WIDTH   (RW)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_item         (r_in),
        .i_use_position (r_use_position),
        .o_flags        (core_flags),
        .o_seg_x        (core_x),
        .o_seg_y        (core_y),
        .o_seg_len      (core_len),
        .o_total        (core_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_flags <= core_flags;
            r_out_x     <= core_x;
            r_out_y     <= core_y;
            r_out_len   <= core_len;
            r_out_total <= core_total;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = TDATA_W'({r_out_total, r_out_len, r_out_y, r_out_x});
    assign m_tuser  = r_out_flags.seg_valid;
    assign m_tlast  = r_out_flags.done;

    `ASSERT_IMP(a_plain_result_is_done, i_clk, i_rst_n, r_out_valid && !r_out_flags.seg_valid, r_out_flags.done, "result without segment is not end of text")
    `ASSERT_IMP(a_seg_len_nonzero, i_clk, i_rst_n, r_out_valid && r_out_flags.seg_valid, r_out_len != '0, "segment of zero length")
    `ASSERT_IMP(a_total_covers_len, i_clk, i_rst_n, r_out_valid && r_out_flags.seg_valid, 33'(r_out_len) <= 33'(r_out_total), "cell total below segment length")
    `ASSERT_NXT(a_load_shows_result, i_clk, i_rst_n, load_out, r_out_valid, "loaded result not presented")

endmodule

@@ tb/tb_life_rle_pattern_decoder_unit.sv @@
// self-checking testbench for life_rle_pattern_decoder_unit: streams rle pattern text,
// predicts segments and end-of-text totals in a local decoder, checks every result transfer
// depends on lrd_pkg and the decoder rtl
module tb_life_rle_pattern_decoder_unit;

    localparam int     COORD_W     = 32;
    localparam int     RUN_W       = 24;
    localparam int     M_WIDTH     = ((2 * COORD_W + RUN_W + 32 + 7) / 8) * 8;
    localparam longint COORD_MAX   = 64'sd2147483647;
    localparam longint COORD_MIN   = -64'sd2147483648;
    localparam longint MAG_LIMIT   = 64'sd2147483648;
    localparam longint RUN_MAX     = 64'sd16777215;
    localparam longint CELLS_MAX   = 64'sd4294967295;
    localparam logic [47:0] HDR_WORD = "#CXRLE";
    localparam logic [31:0] POS_WORD = "Pos=";
    localparam logic [7:0]  CH_BANG  = 8'h21;
    localparam int     RANDOM_BYTES   = 320;
    localparam int     RX_HOLD_CYCLES = 200;
    localparam int     TAIL_CYCLES    = 6;
    localparam int     CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic        seg;
        logic [31:0] x;
        logic [31:0] y;
        logic [23:0] len;
        logic        done;
        logic [31:0] total;
    } t_segment_result;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic               i_cfg_wr_data = 1'b0;
    logic               s_tvalid      = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata       = 8'h00;   // text_byte
    logic               s_tlast       = 1'b0;    // end_of_text
    logic               m_tvalid;
    logic               m_tready      = 1'b0;
    // segment_x, segment_y, segment_length, total_cells
    logic [M_WIDTH-1:0] m_tdata;
    logic               m_tuser;                 // segment_valid
    logic               m_tlast;                 // text_done

    life_rle_pattern_decoder_unit #(
        .COORD_WIDTH(COORD_W),
        .RUN_WIDTH  (RUN_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    // decoder state mirrored by the predictor
    lrd_pkg::t_line_mode dec_mode = lrd_pkg::MODE_NORMAL;
    logic [3:0]  dec_match      = '0;
    logic [31:0] dec_off_x      = '0;
    logic [31:0] dec_off_y      = '0;
    logic [31:0] dec_pos_mag    = '0;
    logic        dec_pos_neg    = 1'b0;
    logic [31:0] dec_cur_x      = '0;
    logic [31:0] dec_cur_y      = '0;
    logic [23:0] dec_run        = '0;
    logic        dec_run_digits = 1'b0;
    logic        dec_halted     = 1'b0;
    logic [31:0] dec_cells      = '0;
    logic        dec_use_pos    = 1'b0;

    t_segment_result    expected_segments[$];
    lrd_pkg::t_in_item  text_bytes_q[$];
    logic [7:0]         text_buf[$];
    lrd_pkg::t_in_item  tx_item;

    int tx_gap_max      = 0;
    int rx_gap_max      = 0;
    int tx_wait         = 0;
    int rx_wait         = 0;
    int rx_hold_left    = 0;
    bit rx_hold_req     = 1'b0;
    int error_count     = 0;
    int bytes_sent      = 0;
    int results_checked = 0;
    int texts_sent      = 0;
    int queued_bytes    = 0;
    int cycle_count     = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("life_rle_pattern_decoder_unit regression: fail");
            $finish;
        end
    end

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic bit is_decimal(input logic [7:0] c);
        return (c >= lrd_pkg::CH_ZERO) && (c <= lrd_pkg::CH_NINE);
    endfunction

    function automatic bit is_pos_blank(input logic [7:0] c);
        return c == lrd_pkg::CH_SPACE || c == lrd_pkg::CH_TAB || c == lrd_pkg::CH_VT ||
               c == lrd_pkg::CH_FF || c == lrd_pkg::CH_CR;
    endfunction

    task automatic clear_decode();
        dec_mode       = lrd_pkg::MODE_NORMAL;
        dec_match      = '0;
        dec_off_x      = '0;
        dec_off_y      = '0;
        dec_pos_mag    = '0;
        dec_pos_neg    = 1'b0;
        dec_cur_x      = '0;
        dec_cur_y      = '0;
        dec_run        = '0;
        dec_run_digits = 1'b0;
        dec_halted     = 1'b0;
        dec_cells      = '0;
    endtask

    task automatic apply_tag(input logic [7:0] c, inout t_segment_result r);
        longint run;
        longint cell_sum;
        run = (dec_run == 0) ? 1 : longint'(dec_run);
        dec_run = '0;
        dec_run_digits = 1'b0;
        case (c)
            lrd_pkg::CH_B: dec_cur_x = clamp_coord(longint'(dec_cur_x) + run);
            lrd_pkg::CH_O: begin
                r.seg = 1'b1;
                r.x = clamp_coord(longint'(dec_cur_x) + longint'($signed(dec_off_x)));
                r.y = clamp_coord(longint'(dec_cur_y) + longint'($signed(dec_off_y)));
                r.len = run[23:0];
                dec_cur_x = clamp_coord(longint'(dec_cur_x) + run);
                cell_sum = longint'(dec_cells) + run;
                dec_cells = (cell_sum > CELLS_MAX) ? 32'hFFFF_FFFF : cell_sum[31:0];
            end
            lrd_pkg::CH_DOLLAR: begin
                dec_cur_y = clamp_coord(longint'(dec_cur_y) + run);
                dec_cur_x = '0;
            end
            default: dec_halted = 1'b1;
        endcase
    endtask

    task automatic pos_number_byte(input logic [7:0] c, input bit for_x);
        logic [3:0] phase;
        longint     d;
        longint     v;
        phase = dec_match;
        if (is_decimal(c)) begin
            d = longint'(c - lrd_pkg::CH_ZERO);
            if (longint'(dec_pos_mag) > (MAG_LIMIT - d) / 10) dec_pos_mag = MAG_LIMIT;
            else dec_pos_mag = dec_pos_mag * 10 + d;
            dec_match = lrd_pkg::PH_DIGITS;
        end else if (is_pos_blank(c) && phase <= lrd_pkg::PH_BLANK) begin
            dec_match = lrd_pkg::PH_BLANK;
        end else if ((c == lrd_pkg::CH_PLUS || c == lrd_pkg::CH_MINUS) &&
                     phase <= lrd_pkg::PH_BLANK) begin
            dec_pos_neg = (c == lrd_pkg::CH_MINUS);
            dec_match = lrd_pkg::PH_SIGN;
        end else begin
            if (phase != lrd_pkg::PH_DIGITS) v = 0;
            else if (dec_pos_neg) v = (dec_pos_mag >= MAG_LIMIT) ? COORD_MIN :
                                      -longint'(dec_pos_mag);
            else v = (dec_pos_mag > COORD_MAX) ? COORD_MAX : longint'(dec_pos_mag);
            if (for_x) dec_off_x = v;
            else dec_off_y = v;
            dec_match = '0;
            dec_pos_mag = '0;
            dec_pos_neg = 1'b0;
            if (for_x && c == lrd_pkg::CH_COMMA &&
                (phase == lrd_pkg::PH_NONE || phase == lrd_pkg::PH_DIGITS))
                dec_mode = lrd_pkg::MODE_POSY;
            else
                dec_mode = (c == lrd_pkg::CH_LF) ? lrd_pkg::MODE_NORMAL
                                                 : lrd_pkg::MODE_COMMENT;
        end
    endtask

    task automatic decode_text_byte(input logic [7:0] c, input logic is_last);
        t_segment_result r;
        longint          d;
        r = '0;
        if (!dec_halted) begin
            case (dec_mode)
                lrd_pkg::MODE_NORMAL: begin
                    if (is_decimal(c)) begin
                        d = longint'(c - lrd_pkg::CH_ZERO);
                        if (longint'(dec_run) > (RUN_MAX - d) / 10) dec_run = RUN_MAX;
                        else dec_run = dec_run * 10 + d;
                        dec_run_digits = 1'b1;
                    end else if (dec_run_digits) begin
                        apply_tag(c, r);
                    end else if (c == lrd_pkg::CH_HASH) begin
                        if (dec_use_pos) begin
                            dec_mode = lrd_pkg::MODE_HEADER;
                            dec_match = 4'd1;
                        end else begin
                            dec_mode = lrd_pkg::MODE_COMMENT;
                        end
                    end else if (c == lrd_pkg::CH_X) begin
                        dec_mode = lrd_pkg::MODE_XCHECK;
                    end else if (c == lrd_pkg::CH_LF || c == lrd_pkg::CH_CR ||
                                 c == lrd_pkg::CH_SPACE) begin
                    end else begin
                        apply_tag(c, r);
                    end
                end
                lrd_pkg::MODE_COMMENT: begin
                    if (c == lrd_pkg::CH_LF) dec_mode = lrd_pkg::MODE_NORMAL;
                end
                lrd_pkg::MODE_HEADER: begin
                    if (dec_match < 6 && c == HDR_WORD[8 * (5 - dec_match) +: 8]) begin
                        dec_match++;
                        if (dec_match == 6) begin
                            dec_mode = lrd_pkg::MODE_SEARCH;
                            dec_match = '0;
                        end
                    end else begin
                        dec_match = '0;
                        dec_mode = (c == lrd_pkg::CH_LF) ? lrd_pkg::MODE_NORMAL
                                                         : lrd_pkg::MODE_COMMENT;
                    end
                end
                lrd_pkg::MODE_SEARCH: begin
                    if (c == lrd_pkg::CH_LF) begin
                        dec_mode = lrd_pkg::MODE_NORMAL;
                        dec_match = '0;
                    end else if (dec_match < 4 && c == POS_WORD[8 * (3 - dec_match) +: 8]) begin
                        dec_match++;
                        if (dec_match == 4) begin
                            dec_mode = lrd_pkg::MODE_POSX;
                            dec_match = '0;
                            dec_pos_mag = '0;
                            dec_pos_neg = 1'b0;
                        end
                    end else begin
                        dec_match = (c == lrd_pkg::CH_P) ? 4'd1 : 4'd0;
                    end
                end
                lrd_pkg::MODE_POSX: pos_number_byte(c, 1'b1);
                lrd_pkg::MODE_POSY: pos_number_byte(c, 1'b0);
                lrd_pkg::MODE_XCHECK: begin
                    if (c == lrd_pkg::CH_SPACE || c == lrd_pkg::CH_EQ) begin
                        dec_mode = lrd_pkg::MODE_COMMENT;
                    end else begin
                        dec_mode = lrd_pkg::MODE_NORMAL;
                        dec_halted = 1'b1;
                    end
                end
                default: dec_mode = lrd_pkg::MODE_NORMAL;
            endcase
            if (c == lrd_pkg::CH_NUL) dec_halted = 1'b1;
        end
        if (r.seg || is_last) begin
            r.done = is_last;
            r.total = dec_cells;
            expected_segments.push_back(r);
        end
        if (is_last) clear_decode();
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        t_segment_result want;
        results_checked++;
        if (expected_segments.size() == 0) begin
            error_count++;
            $display("%0t: result mismatch, expected none, actual tdata %h tuser %b tlast %b",
                     $time, m_tdata, m_tuser, m_tlast);
        end else begin
            want = expected_segments.pop_front();
            check_field("segment_valid", want.seg, m_tuser);
            check_field("segment_x", $signed(want.x), $signed(m_tdata[31:0]));
            check_field("segment_y", $signed(want.y), $signed(m_tdata[63:32]));
            check_field("segment_length", want.len, m_tdata[87:64]);
            check_field("text_done", want.done, m_tlast);
            check_field("total_cells", want.total, m_tdata[119:88]);
        end
    endtask

    // driver: text byte transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_text_byte(s_tdata, s_tlast);
                bytes_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end else if (text_bytes_q.size() != 0) begin
                    tx_item = text_bytes_q.pop_front();
                    s_tdata  <= tx_item.text_byte;
                    s_tlast  <= tx_item.end_of_text;
                    s_tvalid <= 1'b1;
                    tx_wait = $urandom_range(tx_gap_max, 0);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: result transfers and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
                rx_wait = $urandom_range(rx_gap_max, 0);
            end
            if (rx_hold_req) begin
                rx_hold_left = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    task automatic add_random_byte();
        text_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic send_text();
        lrd_pkg::t_in_item item;
        for (int i = 0; i < text_buf.size(); i++) begin
            item.text_byte = text_buf[i];
            item.end_of_text = (i == text_buf.size() - 1);
            text_bytes_q.push_back(item);
        end
        queued_bytes += text_buf.size();
        texts_sent++;
        text_buf.delete();
    endtask

    // sampled away from the active edge so queue and handshake updates have settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (text_bytes_q.size() != 0 || s_tvalid || expected_segments.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_use_position(input bit v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        dec_use_pos = v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic add_pos_number();
        case ($urandom_range(0, 7))
            0: text_buf.push_back(lrd_pkg::CH_TAB);
            1: text_buf.push_back(lrd_pkg::CH_VT);
            2: text_buf.push_back(lrd_pkg::CH_FF);
            3: text_buf.push_back(lrd_pkg::CH_CR);
            4: text_buf.push_back(lrd_pkg::CH_SPACE);
            default: begin
            end
        endcase
        case ($urandom_range(0, 2))
            1: text_buf.push_back(lrd_pkg::CH_PLUS);
            2: text_buf.push_back(lrd_pkg::CH_MINUS);
            default: begin
            end
        endcase
        case ($urandom_range(0, 9))
            0: begin
            end
            1: add_str("2147483647");
            2: add_str("2147483648");
            3: add_str("99999999999");
            4: add_str("0");
            default: add_str($sformatf("%0d", $urandom_range(1, 300)));
        endcase
    endtask

    task automatic add_header();
        case ($urandom_range(0, 9))
            0: add_str("#CXR\n");
            1: add_str("#CXRLE Gen=4\n");
            2: add_str("#CXRLE\nPos=1,1\n");
            default: begin
                add_str("#CXRLE");
                case ($urandom_range(0, 2))
                    0: add_str(" Pos=");
                    1: add_str(" PPos=");
                    default: add_str(" Gen=2 Pos=");
                endcase
                add_pos_number();
                case ($urandom_range(0, 5))
                    0: add_str("\n");
                    1: add_str(" Gen=1\n");
                    default: begin
                        add_str(",");
                        add_pos_number();
                        if ($urandom_range(0, 1)) add_str("\n");
                        else add_str(" Gen=7\n");
                    end
                endcase
            end
        endcase
    endtask

    task automatic build_pattern();
        int n_tok;
        if ($urandom_range(0, 3) == 0) add_str("#N glider\n");
        case ($urandom_range(0, 3))
            0: add_str("x = 12, y = 3, rule = B3/S23\n");
            1: add_str("x=4\n");
            default: begin
            end
        endcase
        if ($urandom_range(0, 1)) add_header();
        n_tok = $urandom_range(1, 12);
        repeat (n_tok) begin
            case ($urandom_range(0, 9))
                4: add_str("0");
                5, 6, 7: add_str($sformatf("%0d", $urandom_range(1, 400)));
                8: begin
                    if ($urandom_range(0, 1)) add_str("16777215");
                    else add_str("99999999999");
                end
                9: begin
                    case ($urandom_range(0, 2))
                        0: text_buf.push_back(lrd_pkg::CH_SPACE);
                        1: text_buf.push_back(lrd_pkg::CH_LF);
                        default: text_buf.push_back(lrd_pkg::CH_CR);
                    endcase
                end
                default: begin
                end
            endcase
            case ($urandom_range(0, 9))
                5, 6: text_buf.push_back(lrd_pkg::CH_B);
                7, 8: text_buf.push_back(lrd_pkg::CH_DOLLAR);
                default: text_buf.push_back(lrd_pkg::CH_O);
            endcase
        end
        case ($urandom_range(0, 9))
            6, 7: begin
            end
            8: add_random_byte();
            9: add_str("3#");
            default: begin
                text_buf.push_back(CH_BANG);
                if ($urandom_range(0, 1)) text_buf.push_back(lrd_pkg::CH_LF);
                else repeat ($urandom_range(1, 3)) add_random_byte();
            end
        endcase
        send_text();
    endtask

    task automatic build_noise();
        case ($urandom_range(0, 3))
            0: begin
                text_buf.push_back(lrd_pkg::CH_X);
                add_random_byte();
                text_buf.push_back(lrd_pkg::CH_O);
            end
            1: add_str("12#o");
            default: repeat ($urandom_range(1, 10)) add_random_byte();
        endcase
        send_text();
    endtask

    initial begin
        int random_start;
        clear_decode();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: size line, zero count, row, stop byte, nul, position header
        tx_gap_max = 8;
        rx_gap_max = 8;
        set_use_position(1'b0);
        add_str("x=2\n2o0b$o");
        text_buf.push_back(8'hFF);
        send_text();
        text_buf.push_back(lrd_pkg::CH_NUL);
        send_text();
        wait_idle();
        set_use_position(1'b1);
        add_str("#CXRLE Pos=-9,4\no");
        send_text();
        wait_idle();

        // receiver hold-off while the sender keeps streaming segments
        tx_gap_max = 0;
        rx_gap_max = 0;
        rx_hold_req = 1'b1;
        repeat (64) text_buf.push_back(lrd_pkg::CH_O);
        text_buf.push_back(CH_BANG);
        send_text();
        wait_idle();

        // saturate run counts, the pos magnitude and segment coordinates
        add_str("#CXRLE Pos=2147483647,-99999999999\n");
        add_str("16777215o$3o99999999999b2o");
        text_buf.push_back(CH_BANG);
        send_text();
        wait_idle();

        random_start = queued_bytes;
        while (queued_bytes - random_start < RANDOM_BYTES) begin
            set_use_position($urandom_range(0, 1));
            tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
            rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
            repeat ($urandom_range(3, 8)) begin
                if ($urandom_range(0, 4) == 0) build_noise();
                else build_pattern();
            end
            wait_idle();
        end

        $display("covered %0d texts, %0d byte transfers, %0d result transfers checked",
                 texts_sent, bytes_sent, results_checked);
        $display("with use_position 0 and 1, a %0d-cycle receiver hold, saturated runs and coords",
                 RX_HOLD_CYCLES);
        if (error_count == 0) begin
            $display("life_rle_pattern_decoder_unit regression: pass");
        end else begin
            $display("%0d mismatches", error_count);
            $display("life_rle_pattern_decoder_unit regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lrd_pkg.sv
rtl/lrd_core.sv
rtl/life_rle_pattern_decoder_unit.sv
tb/tb_life_rle_pattern_decoder_unit.sv
